@@ sv/scil_pkg.sv @@
`default_nettype none

package scil_pkg;

    // Table geometry.
    localparam int MAX_CELLS = 1024;
    localparam int ADDR_W    = $clog2(MAX_CELLS);

    // Fixed field widths.
    localparam int SLOT_W     = 10;
    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 11;
    localparam int TOL_W      = 16;
    localparam int OUT_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Item operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Query modes; the unused code behaves as nearest.
    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_NEXT    = 2'd1;
    localparam logic [1:0] MODE_PREV    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b1;

    // Wide signed type that holds a difference of two coordinate differences.
    typedef logic signed [COORD_W+2:0] t_wide;
    typedef logic [ADDR_W-1:0]         t_addr;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_LAST  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_TIE   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Two values are equal when their absolute difference is below the tolerance.
    function automatic logic f_eq(t_wide a, t_wide b, logic [TOL_W-1:0] tol);
        t_wide d;
        d = a - b;
        if (d < 0) begin
            d = -d;
        end
        return d < $signed({{($bits(t_wide)-TOL_W){1'b0}}, tol});
    endfunction

    function automatic logic f_le(t_wide a, t_wide b, logic [TOL_W-1:0] tol);
        return (a < b) || f_eq(a, b, tol);
    endfunction

    function automatic logic f_lt(t_wide a, t_wide b, logic [TOL_W-1:0] tol);
        return (a < b) && !f_eq(a, b, tol);
    endfunction

    function automatic logic f_ge(t_wide a, t_wide b, logic [TOL_W-1:0] tol);
        return (a > b) || f_eq(a, b, tol);
    endfunction

    function automatic logic f_gt(t_wide a, t_wide b, logic [TOL_W-1:0] tol);
        return (a > b) && !f_eq(a, b, tol);
    endfunction

endpackage

`default_nettype wire

@@ sv/scil_table.sv @@
`default_nettype none

module scil_table
    import scil_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire t_addr                     i_waddr,
    input  wire logic signed [COORD_W-1:0] i_wdata,
    input  wire t_addr                     i_raddr,
    output logic signed [COORD_W-1:0]      o_rdata
);

    // Center storage, one write and one registered read per cycle.
    logic signed [COORD_W-1:0] r_mem [MAX_CELLS];
    logic signed [COORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/sorted_center_index_lookup.sv @@
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_stall      i_op, i_cell_slot, i_center_value,
//                                                   i_position, i_query_mode
// out       source     o_out_valid / i_out_stall    o_cell_index
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load writes the table and leaves the input unstalled. A query reads entry 0 and the
// last entry, then walks the table one entry per cycle through the single read port, and
// the result is registered on the output. Reset is synchronous and active low; it clears
// the sequencer and the output valid, sets cell_count and equal_tolerance to 1 and holds
// off both inputs. The table is not cleared. A stalled result stays in the output
// register; a query that ends meanwhile waits for it.
`default_nettype none

module sorted_center_index_lookup
    import scil_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_op,
    input  wire logic [SLOT_W-1:0]         i_cell_slot,
    input  wire logic signed [COORD_W-1:0] i_center_value,
    input  wire logic signed [COORD_W-1:0] i_position,
    input  wire logic [1:0]                i_query_mode,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [OUT_W-1:0]               o_cell_index,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_state                    r_state, n_state;
    logic [COUNT_W-1:0]        r_cell_count;
    logic [TOL_W-1:0]          r_tol;
    logic signed [COORD_W-1:0] r_pos;
    logic [1:0]                r_mode;
    t_addr                     r_last, n_last;
    t_addr                     r_idx, n_idx;
    t_addr                     r_res, n_res;
    logic signed [COORD_W-1:0] r_first, n_first;
    logic signed [COORD_W-1:0] r_prev, n_prev;
    logic signed [COORD_W-1:0] r_hi, n_hi;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_cell_index;

    logic                      in_accept;
    logic                      query_accept;
    logic                      table_we;
    t_addr                     rd_addr;
    logic signed [COORD_W-1:0] rd_data;
    logic                      out_free;
    logic                      is_next, is_prev;
    t_wide                     w_pos, w_lo, w_hi, w_first;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign query_accept = in_accept && (i_op == OP_QUERY);
    assign table_we     = in_accept && (i_op == OP_LOAD) && (32'(i_cell_slot) < MAX_CELLS);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign is_next      = (r_mode == MODE_NEXT);
    assign is_prev      = (r_mode == MODE_PREV);

    // The configuration port takes a write in any cycle outside reset.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= COUNT_W'(1);
            r_tol        <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CELL_COUNT: r_cell_count <= i_cfg_data[COUNT_W-1:0];
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Last index in use, with a count of zero acting as one and large counts clamped.
    always_comb begin
        if (r_cell_count == '0) begin
            n_last = '0;
        end else if (32'(r_cell_count) > MAX_CELLS) begin
            n_last = ADDR_W'(MAX_CELLS - 1);
        end else begin
            n_last = ADDR_W'(r_cell_count - COUNT_W'(1));
        end
    end

    // Read address for the entry needed in the following cycle.
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_FIRST: rd_addr = r_last;
            S_LAST:  rd_addr = ADDR_W'(1);
            S_SCAN:  rd_addr = r_idx + ADDR_W'(1);
            default: rd_addr = '0;
        endcase
    end

    scil_table u_table (
        .i_clk   (i_clk),
        .i_we    (table_we),
        .i_waddr (ADDR_W'(i_cell_slot)),
        .i_wdata (i_center_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign w_pos   = t_wide'(r_pos);
    assign w_first = t_wide'(r_first);
    assign w_lo    = t_wide'(r_prev);
    assign w_hi    = t_wide'(rd_data);

    // Query sequencer: end checks, then a walk over neighboring pairs.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_res   = r_res;
        n_first = r_first;
        n_prev  = r_prev;
        n_hi    = r_hi;
        case (r_state)
            S_IDLE: begin
                if (query_accept) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_first = rd_data;
                n_state = S_LAST;
            end
            S_LAST: begin
                // Entry 0 sits in r_first and the last entry on the read data.
                if (is_next ? f_lt(w_pos, w_first, r_tol) : f_le(w_pos, w_first, r_tol)) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (is_prev ? f_gt(w_pos, w_hi, r_tol)
                                     : f_ge(w_pos, w_hi, r_tol)) begin
                    n_res   = r_last;
                    n_state = S_DONE;
                end else if (r_last == '0) begin
                    n_res   = r_last;
                    n_state = S_DONE;
                end else begin
                    n_prev  = r_first;
                    n_idx   = ADDR_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (is_next) begin
                    if (f_ge(w_pos, w_lo, r_tol) && f_lt(w_pos, w_hi, r_tol)) begin
                        n_res   = r_idx;
                        n_state = S_DONE;
                    end
                end else if (is_prev) begin
                    if (f_gt(w_pos, w_lo, r_tol) && f_le(w_pos, w_hi, r_tol)) begin
                        n_res   = r_idx - ADDR_W'(1);
                        n_state = S_DONE;
                    end
                end else begin
                    if (f_ge(w_pos, w_lo, r_tol) && f_le(w_pos, w_hi, r_tol)) begin
                        n_hi    = rd_data;
                        n_state = S_TIE;
                    end
                end
                // No bracket in this pair: move on, or give the last index at the end.
                if (n_state == S_SCAN) begin
                    if (r_idx == r_last) begin
                        n_res   = r_last;
                        n_state = S_DONE;
                    end else begin
                        n_prev = rd_data;
                        n_idx  = r_idx + ADDR_W'(1);
                    end
                end
            end
            S_TIE: begin
                // Closer of the two bracketing centers, a tie going to the lower one.
                if (f_le(w_pos - w_lo, t_wide'(r_hi) - w_pos, r_tol)) begin
                    n_res = r_idx - ADDR_W'(1);
                end else begin
                    n_res = r_idx;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Query context and walk registers.
    always_ff @(posedge i_clk) begin
        if (query_accept) begin
            r_pos  <= i_position;
            r_mode <= i_query_mode;
            r_last <= n_last;
        end
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_first <= n_first;
        r_prev  <= n_prev;
        r_hi    <= n_hi;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_cell_index <= OUT_W'(r_res);
        end
    end

    assign o_in_stall   = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_index = r_cell_index;

endmodule

`default_nettype wire

@@ sv/scil_checker.sv @@
`default_nettype none

module scil_checker
    import scil_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               i_op,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [OUT_W-1:0]   o_cell_index
);

    // A query occupies the block for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_op == OP_QUERY)) |=> o_in_stall)
        else $error("input not stalled after a query transaction");

    // A load leaves the input unstalled in the following cycle.
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_op == OP_LOAD)) |=> !o_in_stall)
        else $error("input stalled after a load transaction");

    // A new result only appears at the end of a query.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a query in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_cell_index)))
        else $error("stalled result changed");

endmodule

bind sorted_center_index_lookup scil_checker u_scil_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_op         (i_op),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_cell_index (o_cell_index)
);

`default_nettype wire
